// ----- hdl/ptq_pkg.sv -----
`timescale 1ns / 1ps
// Package for the periodic timer queue: command and result beat types,
// command/status codes, FSM states and the control bundle sent to the cells.
// No dependencies.
package ptq_pkg;

  // Default table size
  localparam int unsigned TIMERS_DEF = 16;

  localparam int unsigned TIME_W   = 63;
  localparam int unsigned PERIOD_W = 40;
  localparam int unsigned ID_W     = 4;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // Command codes
  localparam logic [1:0] CMD_REGISTER = 2'd0;
  localparam logic [1:0] CMD_CANCEL   = 2'd1;
  localparam logic [1:0] CMD_ADVANCE  = 2'd2;

  // Result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_EVENT  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NULL_EXPIRY = 2'd1,
    ST_ARMED       = 2'd2,
    ST_NOT_ARMED   = 2'd3
  } ptq_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT
  } ptq_state_t;

  // Command beat
  typedef struct packed {
    logic [1:0]          command;
    logic [ID_W-1:0]     timer_id;
    logic [TIME_W-1:0]   expiry_time;
    logic [PERIOD_W-1:0] period_us;
    logic [TIME_W-1:0]   now_time;
  } ptq_in_t;

  // Result beat
  typedef struct packed {
    logic              kind;
    logic [ID_W-1:0]   fired_id;
    logic [TIME_W-1:0] fire_time;
    logic [1:0]        status;
    logic              last;
  } ptq_out_t;

  // Control broadcast from the sequencer to every cell
  typedef struct packed {
    logic eval;  // command accepted: latch due flag, load ring token
    logic adv;   // accepted command is an advance
    logic wr;    // arm the addressed slot
    logic clr;   // disarm the addressed slot
    logic step;  // compare held token, then pass it on
    logic fire;  // event beat taken: the hitting cell moves its expiry on
  } ptq_ctl_t;

endpackage

// ----- hdl/ptq_cell.sv -----
`timescale 1ns / 1ps
// One timer slot of the queue: armed flag, expiry, period, due flag, rank
// counter and one stage of the token ring. Depends on ptq_pkg.
module ptq_cell import ptq_pkg::*; #(
  parameter int unsigned TIMERS  = TIMERS_DEF,
  parameter int unsigned CELL_ID = 0
) (
  input  logic                               clk,
  input  logic                               rst,
  input  ptq_ctl_t                           ctl,
  input  ptq_in_t                            cmd,
  input  logic [$clog2(TIMERS+1)-1:0]        k,
  input  logic                               tok_due_in,
  input  logic [TIME_W-1:0]                  tok_exp_in,
  input  logic [$clog2(TIMERS)-1:0]          tok_id_in,
  output logic                               tok_due,
  output logic [TIME_W-1:0]                  tok_exp,
  output logic [$clog2(TIMERS)-1:0]          tok_id,
  output logic                               armed,
  output logic                               sel,
  output logic                               hit
);

  localparam int unsigned IW = $clog2(TIMERS);
  localparam int unsigned CW = $clog2(TIMERS+1);
  localparam logic [IW-1:0] OWN_ID = IW'(CELL_ID);

  logic [TIME_W-1:0]   expiry;
  logic [PERIOD_W-1:0] period;
  logic                due;
  logic [IW-1:0]       rank;

  logic              match;
  logic              due_now;
  logic              less;
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] exp_next;

  // Slot addressing and due test
  assign match   = (32'(cmd.timer_id) == 32'(CELL_ID));
  assign sel     = armed && match;
  assign due_now = armed && (expiry <= cmd.now_time);

  // Held token orders before this slot: lower expiry, then lower id
  assign less = (tok_exp < expiry) || ((tok_exp == expiry) && (tok_id < OWN_ID));

  // Rank equals the emit counter: this slot fires now
  assign hit = due && (CW'(rank) == k);

  // Next expiry, saturated at the time maximum
  assign sum      = {1'b0, expiry} + {{(TIME_W+1-PERIOD_W){1'b0}}, period};
  assign exp_next = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      armed <= 1'b0;
      due   <= 1'b0;
      rank  <= '0;
    end else begin
      if (ctl.wr && match) begin
        armed <= 1'b1;
      end else if (ctl.clr && match) begin
        armed <= 1'b0;
      end
      if (ctl.eval) begin
        due  <= ctl.adv && due_now;
        rank <= '0;
      end else if (ctl.step && tok_due && less) begin
        rank <= rank + 1'b1;
      end
    end
  end

  // Slot payload
  always_ff @(posedge clk) begin
    if (ctl.wr && match) begin
      expiry <= cmd.expiry_time;
      period <= cmd.period_us;
    end else if (ctl.fire && hit) begin
      expiry <= exp_next;
    end
  end

  // Ring token: own key on evaluation, neighbour's key on each step
  always_ff @(posedge clk) begin
    if (ctl.eval) begin
      tok_due <= due_now;
      tok_exp <= expiry;
      tok_id  <= OWN_ID;
    end else if (ctl.step) begin
      tok_due <= tok_due_in;
      tok_exp <= tok_exp_in;
      tok_id  <= tok_id_in;
    end
  end

endmodule

// ----- hdl/periodic_timer_queue_core.sv -----
`timescale 1ns / 1ps
// Top level of the periodic timer queue: command sequencer, result beat
// and the ring of timer cells. Depends on ptq_pkg and ptq_cell.
//
// The block takes one command at a time. Register and cancel act as the
// command is accepted and present their status beat in the next cycle.
// Advance first ranks the due timers by passing every slot's key once round
// the ring of TIMERS cells, then sends one event beat per fired timer in
// ascending expiry order (lower id on ties) and a closing status beat.
// Each fired timer's expiry advances by its period, saturating at the
// largest time value. Ids at or beyond TIMERS answer "not armed".
module periodic_timer_queue_core import ptq_pkg::*; #(
  parameter int unsigned TIMERS = TIMERS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     cmd_valid,
  output logic     cmd_ready,
  input  ptq_in_t  cmd,
  output logic     res_valid,
  input  logic     res_ready,
  output ptq_out_t res
);

  localparam int unsigned IW = $clog2(TIMERS);
  localparam int unsigned CW = $clog2(TIMERS+1);

  ptq_state_t state, state_next;
  ptq_ctl_t   ctl;

  logic [IW-1:0]     scan_cnt;
  logic [CW-1:0]     k;
  logic [TIME_W-1:0] now_q;
  ptq_status_t       st;
  ptq_status_t       st_new;

  logic cmd_fire;
  logic res_fire;
  logic in_range;
  logic sel_any;
  logic any_hit;
  logic [IW-1:0] hit_id;

  logic [TIMERS-1:0] armed_v;
  logic [TIMERS-1:0] sel_v;
  logic [TIMERS-1:0] hit_v;
  logic [TIMERS-1:0] tok_due_v;
  logic [TIME_W-1:0] tok_exp_v [TIMERS];
  logic [IW-1:0]     tok_id_v  [TIMERS];

  assign cmd_fire = cmd_valid && cmd_ready;
  assign res_fire = res_valid && res_ready;
  assign in_range = (32'(cmd.timer_id) < 32'(TIMERS));
  assign sel_any  = |sel_v;
  assign any_hit  = |hit_v;

  // Cell row, tokens wired as a ring
  for (genvar i = 0; i < TIMERS; i++) begin : g_cell
    localparam int unsigned PREV = (i == 0) ? TIMERS - 1 : i - 1;
    ptq_cell #(
      .TIMERS  (TIMERS),
      .CELL_ID (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .cmd        (cmd),
      .k          (k),
      .tok_due_in (tok_due_v[PREV]),
      .tok_exp_in (tok_exp_v[PREV]),
      .tok_id_in  (tok_id_v[PREV]),
      .tok_due    (tok_due_v[i]),
      .tok_exp    (tok_exp_v[i]),
      .tok_id     (tok_id_v[i]),
      .armed      (armed_v[i]),
      .sel        (sel_v[i]),
      .hit        (hit_v[i])
    );
  end

  // Id of the cell that fires now (at most one hits)
  always_comb begin
    hit_id = '0;
    for (int i = 0; i < TIMERS; i++) begin
      if (hit_v[i]) begin
        hit_id = hit_id | IW'(i);
      end
    end
  end

  // Status of the incoming command
  always_comb begin
    st_new = ST_OK;
    if (cmd.command == CMD_REGISTER) begin
      if (cmd.expiry_time == '0) begin
        st_new = ST_NULL_EXPIRY;
      end else if (!in_range) begin
        st_new = ST_NOT_ARMED;
      end else if (sel_any) begin
        st_new = ST_ARMED;
      end
    end else if (cmd.command == CMD_CANCEL) begin
      if (!in_range || !sel_any) begin
        st_new = ST_NOT_ARMED;
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd_fire) begin
          state_next = (cmd.command == CMD_ADVANCE) ? S_SCAN : S_EMIT;
        end
      end
      S_SCAN: begin
        if (scan_cnt == IW'(TIMERS - 1)) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (res_fire && !any_hit) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    cmd_ready = (state == S_IDLE);
    res_valid = (state == S_EMIT);
    ctl.eval  = cmd_fire;
    ctl.adv   = (cmd.command == CMD_ADVANCE);
    ctl.wr    = cmd_fire && (cmd.command == CMD_REGISTER) && (st_new == ST_OK);
    ctl.clr   = cmd_fire && (cmd.command == CMD_CANCEL);
    ctl.step  = (state == S_SCAN);
    ctl.fire  = res_fire && any_hit;
  end

  // Result beat: event while a cell hits, then the closing status
  always_comb begin
    if (any_hit) begin
      res.kind      = KIND_EVENT;
      res.fired_id  = ID_W'(hit_id);
      res.fire_time = now_q;
      res.status    = ST_OK;
      res.last      = 1'b0;
    end else begin
      res.kind      = KIND_STATUS;
      res.fired_id  = '0;
      res.fire_time = '0;
      res.status    = st;
      res.last      = 1'b1;
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Scan and emit counters
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt <= '0;
      k        <= '0;
    end else begin
      if (cmd_fire) begin
        scan_cnt <= '0;
        k        <= '0;
      end else begin
        if (state == S_SCAN) begin
          scan_cnt <= scan_cnt + 1'b1;
        end
        if (ctl.fire) begin
          k <= k + 1'b1;
        end
      end
    end
  end

  // Command payload kept for the result beats
  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      now_q <= cmd.now_time;
      st    <= st_new;
    end
  end

  // Once ranking is done, ranks are unique, so no two cells fire together
  a_one_hit: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> $onehot0(hit_v))
    else $error("more than one timer cell hit");

  // Scan never runs past the ring length
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (32'(scan_cnt) < 32'(TIMERS)))
    else $error("scan counter beyond ring length");

  // The closing beat returns the block to taking commands
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (res_fire && res.last) |=> cmd_ready)
    else $error("not ready after closing beat");

  // Events only follow an advance scan
  a_event_after_scan: assert property (@(posedge clk) disable iff (rst)
    ($rose(res_valid) && (res.kind == KIND_EVENT)) |-> ($past(state) == S_SCAN))
    else $error("event beat without a scan");

  // A register that arms a slot only arms one that was free
  a_wr_free: assert property (@(posedge clk) disable iff (rst)
    ctl.wr |=> ($countones(armed_v) == $countones($past(armed_v)) + 1))
    else $error("register did not arm exactly one new slot");

endmodule

// ----- dv/periodic_timer_queue_core_tb.sv -----
`timescale 1ns / 1ps
// Testbench for periodic_timer_queue_core: directed table then random commands,
// every result beat checked against a typed-in status or an in-bench model of the timer table.
// Depends on ptq_pkg and periodic_timer_queue_core.
module periodic_timer_queue_core_tb;
  import ptq_pkg::*;

  localparam int unsigned TIMERS       = TIMERS_DEF;
  localparam int          RAND_ITEMS   = 350;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          HOLD_AT      = 120;
  localparam int          DRAIN_AT     = 240;
  localparam int          BURST_FROM   = 170;
  localparam int          BURST_TO     = 220;
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX = {PERIOD_W{1'b1}};

  // Directed row: a command beat, and a status typed in where it is obvious
  typedef struct packed {
    ptq_in_t     beat;
    logic        typed;
    ptq_status_t want;
  } dir_row_t;

  localparam int DIR_ROWS = 23;
  dir_row_t dir_tbl [DIR_ROWS] = '{
    '{'{CMD_CANCEL,   4'd0,  63'd0, 40'd0, 63'd0},    1'b1, ST_NOT_ARMED},
    '{'{CMD_ADVANCE,  4'd0,  63'd0, 40'd0, TIME_MAX}, 1'b1, ST_OK},
    '{'{CMD_REGISTER, 4'd0,  63'd0, PERIOD_MAX, 63'd0}, 1'b1, ST_NULL_EXPIRY},
    '{'{CMD_REGISTER, 4'd0,  63'd1, 40'd0, 63'd0},    1'b1, ST_OK},
    '{'{CMD_REGISTER, 4'd0,  63'd5, 40'd3, 63'd0},    1'b1, ST_ARMED},
    '{'{CMD_REGISTER, 4'd0,  63'd0, 40'd3, 63'd0},    1'b1, ST_NULL_EXPIRY},
    '{'{CMD_REGISTER, 4'd15, TIME_MAX, PERIOD_MAX, 63'd0}, 1'b1, ST_OK},
    '{'{CMD_REGISTER, 4'd7,  TIME_MAX - 63'd3, 40'd10, 63'd0}, 1'b1, ST_OK},
    '{'{CMD_REGISTER, 4'd3,  63'd100, 40'd50, 63'd0}, 1'b1, ST_OK},
    '{'{CMD_REGISTER, 4'd4,  63'd100, 40'd1, 63'd0},  1'b1, ST_OK},
    '{'{CMD_REGISTER, 4'd9,  63'd100, 40'd0, 63'd0},  1'b1, ST_OK},
    '{'{CMD_UNUSED,   4'd15, TIME_MAX, PERIOD_MAX, TIME_MAX}, 1'b1, ST_OK},
    '{'{CMD_ADVANCE,  4'd0,  63'd0, 40'd0, 63'd0},    1'b0, ST_OK},
    '{'{CMD_ADVANCE,  4'd0,  63'd0, 40'd0, 63'd99},   1'b0, ST_OK},
    '{'{CMD_ADVANCE,  4'd0,  63'd0, 40'd0, 63'd100},  1'b0, ST_OK},
    '{'{CMD_ADVANCE,  4'd0,  63'd0, 40'd0, 63'd100},  1'b0, ST_OK},
    '{'{CMD_CANCEL,   4'd9,  63'd0, 40'd0, 63'd0},    1'b1, ST_OK},
    '{'{CMD_CANCEL,   4'd9,  63'd0, 40'd0, 63'd0},    1'b1, ST_NOT_ARMED},
    '{'{CMD_ADVANCE,  4'd0,  63'd0, 40'd0, TIME_MAX - 63'd1}, 1'b0, ST_OK},
    '{'{CMD_ADVANCE,  4'd0,  63'd0, 40'd0, TIME_MAX}, 1'b0, ST_OK},
    '{'{CMD_ADVANCE,  4'd0,  63'd0, 40'd0, TIME_MAX}, 1'b0, ST_OK},
    '{'{CMD_CANCEL,   4'd15, 63'd0, 40'd0, 63'd0},    1'b1, ST_OK},
    '{'{CMD_CANCEL,   4'd15, 63'd0, 40'd0, 63'd0},    1'b1, ST_NOT_ARMED}
  };

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     cmd_valid = 1'b0;
  logic     cmd_ready;
  ptq_in_t  cmd = '0;
  logic     res_valid;
  logic     res_ready = 1'b0;
  ptq_out_t res;

  // Model of the timer table
  logic                slot_armed  [TIMERS];
  logic [TIME_W-1:0]   slot_expiry [TIMERS];
  logic [PERIOD_W-1:0] slot_period [TIMERS];

  ptq_out_t pending_res [$];
  int       mismatches = 0;
  bit       hold_req   = 1'b0;
  bit       no_idle    = 1'b0;

  periodic_timer_queue_core #(.TIMERS(TIMERS)) DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("periodic_timer_queue_core verification failed");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("%0t ns: %s mismatch, got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Apply one command to the model; queue its beats unless keep is low
  task automatic predict_command(input ptq_in_t c, input bit keep);
    ptq_status_t st;
    bit          due [TIMERS];
    int          best;
    logic [63:0] sum;
    ptq_out_t    beat;
    st = ST_OK;
    case (c.command)
      CMD_REGISTER: begin
        if (c.expiry_time == '0) begin
          st = ST_NULL_EXPIRY;
        end else if (int'(c.timer_id) >= TIMERS) begin
          st = ST_NOT_ARMED;
        end else if (slot_armed[c.timer_id]) begin
          st = ST_ARMED;
        end else begin
          slot_armed[c.timer_id]  = 1'b1;
          slot_expiry[c.timer_id] = c.expiry_time;
          slot_period[c.timer_id] = c.period_us;
        end
      end
      CMD_CANCEL: begin
        if (int'(c.timer_id) >= TIMERS || !slot_armed[c.timer_id]) begin
          st = ST_NOT_ARMED;
        end else begin
          slot_armed[c.timer_id] = 1'b0;
        end
      end
      CMD_ADVANCE: begin
        // due set is frozen from the expiries before this advance
        for (int i = 0; i < TIMERS; i++) begin
          due[i] = slot_armed[i] && (slot_expiry[i] <= c.now_time);
        end
        forever begin
          best = -1;
          for (int i = 0; i < TIMERS; i++) begin
            if (due[i] && (best < 0 || slot_expiry[i] < slot_expiry[best])) best = i;
          end
          if (best < 0) break;
          due[best] = 1'b0;
          beat = '{KIND_EVENT, ID_W'(best), c.now_time, ST_OK, 1'b0};
          if (keep) pending_res.push_back(beat);
          sum = 64'(slot_expiry[best]) + 64'(slot_period[best]);
          slot_expiry[best] = (sum > 64'(TIME_MAX)) ? TIME_MAX : sum[TIME_W-1:0];
        end
      end
      default: ;
    endcase
    beat = '{KIND_STATUS, '0, '0, st, 1'b1};
    if (keep) pending_res.push_back(beat);
  endtask

  // Offer one command beat and hold it until taken; returns at a falling edge
  task automatic send_command(input ptq_in_t c, input bit typed, input ptq_status_t want);
    int       gap;
    ptq_out_t beat;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd       <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (!cmd_ready);
    predict_command(c, !typed);
    if (typed) begin
      beat = '{KIND_STATUS, '0, '0, want, 1'b1};
      pending_res.push_back(beat);
    end
    @(negedge clk);
  endtask

  // Random command, mostly registers and advances around a moving time base
  function automatic ptq_in_t make_random(ref logic [TIME_W-1:0] wall);
    ptq_in_t c;
    int      pick;
    logic [63:0] w;
    w = rand64();
    c.expiry_time = w[TIME_W-1:0];
    w = rand64();
    c.period_us = w[PERIOD_W-1:0];
    w = rand64();
    c.now_time = w[TIME_W-1:0];
    c.timer_id = ID_W'($urandom_range(0, TIMERS - 1));
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      c.command = CMD_REGISTER;
      pick = $urandom_range(0, 99);
      if (pick < 5) c.expiry_time = '0;
      else if (pick < 85) c.expiry_time = wall + TIME_W'($urandom_range(0, 400));
      pick = $urandom_range(0, 99);
      if (pick < 15) c.period_us = '0;
      else if (pick < 85) c.period_us = PERIOD_W'($urandom_range(1, 200));
    end else if (pick < 60) begin
      c.command = CMD_CANCEL;
    end else if (pick < 96) begin
      c.command = CMD_ADVANCE;
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        wall = wall + TIME_W'($urandom_range(0, 150));
        c.now_time = wall;
      end else if (pick < 80) begin
        c.now_time = wall;
      end else if (pick < 90) begin
        c.now_time = TIME_MAX - TIME_W'($urandom_range(0, 3));
      end
    end else begin
      c.command = CMD_UNUSED;
    end
    // now and then restart the time base low
    if ($urandom_range(0, 99) == 0) wall = TIME_W'($urandom_range(1, 1000));
    return c;
  endfunction

  // Command side
  initial begin
    logic [TIME_W-1:0] wall;
    ptq_in_t           c;
    for (int i = 0; i < TIMERS; i++) begin
      slot_armed[i]  = 1'b0;
      slot_expiry[i] = '0;
      slot_period[i] = '0;
    end
    wall = TIME_W'(1000);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int r = 0; r < DIR_ROWS; r++) begin
      send_command(dir_tbl[r].beat, dir_tbl[r].typed, dir_tbl[r].want);
    end

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == HOLD_AT) hold_req = 1'b1;
      no_idle = (n >= BURST_FROM && n < BURST_TO);
      if (n == DRAIN_AT) begin
        // pause the command side until every beat owed has come back
        cmd_valid <= 1'b0;
        while (pending_res.size() != 0) @(posedge clk);
        @(negedge clk);
      end
      c = make_random(wall);
      send_command(c, 1'b0, ST_OK);
    end
    cmd_valid <= 1'b0;

    while (pending_res.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("periodic_timer_queue_core verification clean");
    end else begin
      $display("periodic_timer_queue_core verification failed");
    end
    $finish;
  end

  // Result side: random ready gaps, one long hold-off on request
  initial begin
    int       gap;
    ptq_out_t got;
    ptq_out_t want;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        res_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      res_ready <= 1'b1;
      do @(posedge clk); while (!res_valid);
      got = res;
      if (pending_res.size() == 0) begin
        note_mismatch("unexpected result beat", 64'(got.fired_id), 64'(got.status));
      end else begin
        want = pending_res.pop_front();
        if (got.kind !== want.kind) note_mismatch("kind", 64'(got.kind), 64'(want.kind));
        if (got.fired_id !== want.fired_id)
          note_mismatch("fired_id", 64'(got.fired_id), 64'(want.fired_id));
        if (got.fire_time !== want.fire_time)
          note_mismatch("fire_time", 64'(got.fire_time), 64'(want.fire_time));
        if (got.status !== want.status)
          note_mismatch("status", 64'(got.status), 64'(want.status));
        if (got.last !== want.last) note_mismatch("last", 64'(got.last), 64'(want.last));
      end
    end
  end

endmodule
